// ----- hdl/bmcf_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and the job type of the Bode margin crossing finder.
package bmcf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int T_W       = FRAC_BITS + 1;
  localparam int CNT_W     = $clog2(FRAC_BITS);

  localparam int FREQ_W  = 40;
  localparam int GAIN_W  = 32;
  localparam int PHASE_W = 26;
  localparam int MAG_W   = 33;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam int ONE_Q16 = 65536;

  localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;

  localparam logic signed [PHASE_W-1:0] PH_M181 = PHASE_W'(-181 * ONE_Q16);
  localparam logic signed [PHASE_W-1:0] PH_M180 = PHASE_W'(-180 * ONE_Q16);
  localparam logic signed [PHASE_W-1:0] PH_M179 = PHASE_W'(-179 * ONE_Q16);

  localparam logic signed [GAIN_W-1:0] PM_BASE  = GAIN_W'(180 * ONE_Q16);
  localparam logic signed [GAIN_W-1:0] GAIN_MAX = GAIN_W'(32'h7FFF_FFFF);

  typedef struct packed {
    logic [FREQ_W-1:0]         f0;
    logic [FREQ_W-1:0]         f1;
    logic signed [GAIN_W-1:0]  g0;
    logic signed [GAIN_W-1:0]  g1;
    logic signed [PHASE_W-1:0] p0;
    logic signed [PHASE_W-1:0] p1;
    logic                      do_gain;
    logic                      do_phase;
    logic                      last;
  } job_t;

endpackage

// ----- hdl/bode_margin_crossing_finder_unit.sv -----
`timescale 1ns / 1ps
// Top level of the Bode margin crossing finder.
//
//  channel  direction  handshake             payload
//  in_      input      in_valid / in_ready   freq_hz, gain_db, phase_deg, last_point
//  out_     output     out_valid / out_ready gain/phase crossing flags, freqs, margins
//
// A point is taken each cycle while the two-entry job queue has room.
// The back end takes a queued job while idle, then works each crossing through
// setup, a serial divide of one quotient bit a cycle, multiply and add; the divide
// is skipped when the fraction is 0 or 1, and a last point adds a step to load the result beat.
// Synchronous reset clears the sweep, the queue, the held margins and the result valid flag.
// Each side stalls on its own: the queue and the result register part them.
module bode_margin_crossing_finder_unit import bmcf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [FREQ_W-1:0]         in_freq_hz,
  input  logic signed [GAIN_W-1:0]  in_gain_db,
  input  logic signed [PHASE_W-1:0] in_phase_deg,
  input  logic                      in_last_point,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_gain_cross_found,
  output logic [FREQ_W-1:0]         out_gain_cross_freq,
  output logic signed [GAIN_W-1:0]  out_phase_margin,
  output logic                      out_phase_cross_found,
  output logic [FREQ_W-1:0]         out_phase_cross_freq,
  output logic signed [GAIN_W-1:0]  out_gain_margin
);

  logic push;
  logic q_full;
  logic q_valid;
  logic q_pop;
  job_t job_in;
  job_t job_out;

  bmcf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_freq_hz    (in_freq_hz),
    .in_gain_db    (in_gain_db),
    .in_phase_deg  (in_phase_deg),
    .in_last_point (in_last_point),
    .q_full        (q_full),
    .push          (push),
    .job           (job_in)
  );

  bmcf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .job_in  (job_in),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .job_out (job_out)
  );

  bmcf_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_valid               (q_valid),
    .q_job                 (job_out),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_gain_cross_found  (out_gain_cross_found),
    .out_gain_cross_freq   (out_gain_cross_freq),
    .out_phase_margin      (out_phase_margin),
    .out_phase_cross_found (out_phase_cross_found),
    .out_phase_cross_freq  (out_phase_cross_freq),
    .out_gain_margin       (out_gain_margin)
  );

endmodule

// ----- hdl/bmcf_front.sv -----
`timescale 1ns / 1ps
// Front end: takes Bode points, keeps the previous one and flags crossings.
module bmcf_front import bmcf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [FREQ_W-1:0]         in_freq_hz,
  input  logic signed [GAIN_W-1:0]  in_gain_db,
  input  logic signed [PHASE_W-1:0] in_phase_deg,
  input  logic                      in_last_point,
  input  logic                      q_full,
  output logic                      push,
  output job_t                      job
);

  logic                      have_prev_r, have_prev_nxt;
  logic                      gain_done_r, gain_done_nxt;
  logic                      phase_done_r, phase_done_nxt;
  logic [FREQ_W-1:0]         prev_f_r;
  logic signed [GAIN_W-1:0]  prev_g_r;
  logic signed [PHASE_W-1:0] prev_p_r;
  logic                      fire;
  logic                      gain_x;
  logic                      phase_x;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  assign gain_x = have_prev_r && !gain_done_r &&
                  (prev_g_r[GAIN_W-1] != in_gain_db[GAIN_W-1]);
  assign phase_x = have_prev_r && !phase_done_r &&
                   (((prev_p_r > PH_M181) && (in_phase_deg <= PH_M180)) ||
                    ((prev_p_r < PH_M179) && (in_phase_deg >= PH_M180)));

  assign push = fire && (gain_x || phase_x || in_last_point);

  always_comb begin
    job.f0       = prev_f_r;
    job.f1       = in_freq_hz;
    job.g0       = prev_g_r;
    job.g1       = in_gain_db;
    job.p0       = prev_p_r;
    job.p1       = in_phase_deg;
    job.do_gain  = gain_x;
    job.do_phase = phase_x;
    job.last     = in_last_point;
  end

  always_comb begin
    have_prev_nxt  = have_prev_r;
    gain_done_nxt  = gain_done_r;
    phase_done_nxt = phase_done_r;
    if (fire) begin
      if (in_last_point) begin
        have_prev_nxt  = 1'b0;
        gain_done_nxt  = 1'b0;
        phase_done_nxt = 1'b0;
      end else begin
        have_prev_nxt  = 1'b1;
        gain_done_nxt  = gain_done_r || gain_x;
        phase_done_nxt = phase_done_r || phase_x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r  <= 1'b0;
      gain_done_r  <= 1'b0;
      phase_done_r <= 1'b0;
    end else begin
      have_prev_r  <= have_prev_nxt;
      gain_done_r  <= gain_done_nxt;
      phase_done_r <= phase_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      prev_f_r <= in_freq_hz;
      prev_g_r <= in_gain_db;
      prev_p_r <= in_phase_deg;
    end
  end

  a_gain_done_has_prev: assert property (@(posedge clk) disable iff (!rst_n)
    gain_done_r |-> have_prev_r)
    else $error("gain crossing marked without a previous point");

  a_phase_done_has_prev: assert property (@(posedge clk) disable iff (!rst_n)
    phase_done_r |-> have_prev_r)
    else $error("phase crossing marked without a previous point");

endmodule

// ----- hdl/bmcf_queue.sv -----
`timescale 1ns / 1ps
// Short job queue between the front end and the interpolation back end.
module bmcf_queue import bmcf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t job_in,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t job_out
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign valid   = (cnt_r != '0);
  assign job_out = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= job_in;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job pushed into a full queue");

endmodule

// ----- hdl/bmcf_back.sv -----
`timescale 1ns / 1ps
// Back end: serial fraction divide, interpolation and result beat.
module bmcf_back import bmcf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  job_t                     q_job,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_gain_cross_found,
  output logic [FREQ_W-1:0]        out_gain_cross_freq,
  output logic signed [GAIN_W-1:0] out_phase_margin,
  output logic                     out_phase_cross_found,
  output logic [FREQ_W-1:0]        out_phase_cross_freq,
  output logic signed [GAIN_W-1:0] out_gain_margin
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  localparam logic SEL_GAIN  = 1'b0;
  localparam logic SEL_PHASE = 1'b1;

  localparam int SW = MAG_W + 1;

  logic [2:0]               state_r, state_nxt;
  logic                     sel_r, sel_nxt;
  job_t                     job_r, job_nxt;
  logic [T_W-1:0]           t_r, t_nxt;
  logic [MAG_W-1:0]         rem_r, rem_nxt;
  logic [MAG_W-1:0]         den_r, den_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [FREQ_W-1:0]        fd_mag_r, fd_mag_nxt;
  logic                     fd_neg_r, fd_neg_nxt;
  logic [MAG_W-1:0]         vd_mag_r, vd_mag_nxt;
  logic                     vd_neg_r, vd_neg_nxt;
  logic [FREQ_W-1:0]        pf_r, pf_nxt;
  logic [MAG_W-1:0]         pv_r, pv_nxt;

  logic                     gfound_r, gfound_nxt;
  logic                     pfound_r, pfound_nxt;
  logic [FREQ_W-1:0]        h_gfreq_r, h_gfreq_nxt;
  logic signed [GAIN_W-1:0] h_pm_r, h_pm_nxt;
  logic [FREQ_W-1:0]        h_pfreq_r, h_pfreq_nxt;
  logic signed [GAIN_W-1:0] h_gm_r, h_gm_nxt;

  logic                     ov_r, ov_nxt;
  logic                     o_gf_r, o_gf_nxt;
  logic [FREQ_W-1:0]        o_gfreq_r, o_gfreq_nxt;
  logic signed [GAIN_W-1:0] o_pm_r, o_pm_nxt;
  logic                     o_pf_r, o_pf_nxt;
  logic [FREQ_W-1:0]        o_pfreq_r, o_pfreq_nxt;
  logic signed [GAIN_W-1:0] o_gm_r, o_gm_nxt;

  logic signed [SW-1:0]     g0_s, g1_s, p0_s, p1_s;
  logic signed [SW-1:0]     num_s, den_s, vd_s, val_a, val_res, val_neg;
  logic signed [FREQ_W:0]   fd_s;
  logic [MAG_W-1:0]         num_mag, den_mag;
  logic                     t_zero;
  logic [MAG_W:0]           rem2;
  logic                     ge;
  logic [FREQ_W+T_W-1:0]    pf_full;
  logic [MAG_W+T_W-1:0]     pv_full;
  logic [FREQ_W-1:0]        freq_res;

  assign g0_s = {{(SW-GAIN_W){job_r.g0[GAIN_W-1]}}, job_r.g0};
  assign g1_s = {{(SW-GAIN_W){job_r.g1[GAIN_W-1]}}, job_r.g1};
  assign p0_s = {{(SW-PHASE_W){job_r.p0[PHASE_W-1]}}, job_r.p0};
  assign p1_s = {{(SW-PHASE_W){job_r.p1[PHASE_W-1]}}, job_r.p1};

  always_comb begin
    if (sel_r == SEL_GAIN) begin
      num_s  = g0_s;
      den_s  = g0_s - g1_s;
      vd_s   = p1_s - p0_s;
      t_zero = (den_s == '0);
    end else begin
      num_s  = {{(SW-PHASE_W){PH_M180[PHASE_W-1]}}, PH_M180} - p0_s;
      den_s  = p1_s - p0_s;
      vd_s   = g1_s - g0_s;
      t_zero = (den_s == '0) || (num_s == '0) || (num_s[SW-1] != den_s[SW-1]);
    end
  end

  assign num_mag = num_s[SW-1] ? MAG_W'(-num_s) : MAG_W'(num_s);
  assign den_mag = den_s[SW-1] ? MAG_W'(-den_s) : MAG_W'(den_s);
  assign fd_s    = $signed({1'b0, job_r.f1}) - $signed({1'b0, job_r.f0});

  assign rem2 = {rem_r, 1'b0};
  assign ge   = (rem2 >= {1'b0, den_r});

  assign pf_full = fd_mag_r * t_r;
  assign pv_full = vd_mag_r * t_r;

  assign freq_res = fd_neg_r ? (job_r.f0 - pf_r) : (job_r.f0 + pf_r);
  assign val_a    = (sel_r == SEL_GAIN) ? p0_s : g0_s;
  assign val_res  = vd_neg_r ? (val_a - $signed({1'b0, pv_r}))
                             : (val_a + $signed({1'b0, pv_r}));
  assign val_neg  = -val_res;

  assign q_pop = (state_r == S_IDLE) && q_valid;

  always_comb begin
    state_nxt   = state_r;
    sel_nxt     = sel_r;
    job_nxt     = job_r;
    t_nxt       = t_r;
    rem_nxt     = rem_r;
    den_nxt     = den_r;
    cnt_nxt     = cnt_r;
    fd_mag_nxt  = fd_mag_r;
    fd_neg_nxt  = fd_neg_r;
    vd_mag_nxt  = vd_mag_r;
    vd_neg_nxt  = vd_neg_r;
    pf_nxt      = pf_r;
    pv_nxt      = pv_r;
    gfound_nxt  = gfound_r;
    pfound_nxt  = pfound_r;
    h_gfreq_nxt = h_gfreq_r;
    h_pm_nxt    = h_pm_r;
    h_pfreq_nxt = h_pfreq_r;
    h_gm_nxt    = h_gm_r;
    ov_nxt      = ov_r && !out_ready;
    o_gf_nxt    = o_gf_r;
    o_gfreq_nxt = o_gfreq_r;
    o_pm_nxt    = o_pm_r;
    o_pf_nxt    = o_pf_r;
    o_pfreq_nxt = o_pfreq_r;
    o_gm_nxt    = o_gm_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          job_nxt   = q_job;
          sel_nxt   = q_job.do_gain ? SEL_GAIN : SEL_PHASE;
          state_nxt = (q_job.do_gain || q_job.do_phase) ? S_SETUP : S_EMIT;
        end
      end
      S_SETUP: begin
        fd_neg_nxt = fd_s[FREQ_W];
        fd_mag_nxt = fd_s[FREQ_W] ? FREQ_W'(-fd_s) : FREQ_W'(fd_s);
        vd_neg_nxt = vd_s[SW-1];
        vd_mag_nxt = vd_s[SW-1] ? MAG_W'(-vd_s) : MAG_W'(vd_s);
        den_nxt    = den_mag;
        rem_nxt    = num_mag;
        cnt_nxt    = '0;
        if (t_zero) begin
          t_nxt     = '0;
          state_nxt = S_MUL;
        end else if (num_mag >= den_mag) begin
          t_nxt     = T_ONE;
          state_nxt = S_MUL;
        end else begin
          t_nxt     = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = ge ? MAG_W'(rem2 - {1'b0, den_r}) : MAG_W'(rem2);
        t_nxt   = {t_r[T_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(FRAC_BITS-1)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        pf_nxt    = pf_full[FRAC_BITS +: FREQ_W];
        pv_nxt    = pv_full[FRAC_BITS +: MAG_W];
        state_nxt = S_ADD;
      end
      S_ADD: begin
        if (sel_r == SEL_GAIN) begin
          gfound_nxt  = 1'b1;
          h_gfreq_nxt = freq_res;
          h_pm_nxt    = PM_BASE + GAIN_W'(val_res);
        end else begin
          pfound_nxt  = 1'b1;
          h_pfreq_nxt = freq_res;
          h_gm_nxt    = (val_neg > SW'(GAIN_MAX)) ? GAIN_MAX : GAIN_W'(val_neg);
        end
        if ((sel_r == SEL_GAIN) && job_r.do_phase) begin
          sel_nxt   = SEL_PHASE;
          state_nxt = S_SETUP;
        end else if (job_r.last) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!ov_r || out_ready) begin
          ov_nxt      = 1'b1;
          o_gf_nxt    = gfound_r;
          o_gfreq_nxt = h_gfreq_r;
          o_pm_nxt    = h_pm_r;
          o_pf_nxt    = pfound_r;
          o_pfreq_nxt = h_pfreq_r;
          o_gm_nxt    = h_gm_r;
          gfound_nxt  = 1'b0;
          pfound_nxt  = 1'b0;
          h_gfreq_nxt = '0;
          h_pm_nxt    = '0;
          h_pfreq_nxt = '0;
          h_gm_nxt    = '0;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ov_r      <= 1'b0;
      gfound_r  <= 1'b0;
      pfound_r  <= 1'b0;
      h_gfreq_r <= '0;
      h_pm_r    <= '0;
      h_pfreq_r <= '0;
      h_gm_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      ov_r      <= ov_nxt;
      gfound_r  <= gfound_nxt;
      pfound_r  <= pfound_nxt;
      h_gfreq_r <= h_gfreq_nxt;
      h_pm_r    <= h_pm_nxt;
      h_pfreq_r <= h_pfreq_nxt;
      h_gm_r    <= h_gm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r     <= sel_nxt;
    job_r     <= job_nxt;
    t_r       <= t_nxt;
    rem_r     <= rem_nxt;
    den_r     <= den_nxt;
    cnt_r     <= cnt_nxt;
    fd_mag_r  <= fd_mag_nxt;
    fd_neg_r  <= fd_neg_nxt;
    vd_mag_r  <= vd_mag_nxt;
    vd_neg_r  <= vd_neg_nxt;
    pf_r      <= pf_nxt;
    pv_r      <= pv_nxt;
    o_gf_r    <= o_gf_nxt;
    o_gfreq_r <= o_gfreq_nxt;
    o_pm_r    <= o_pm_nxt;
    o_pf_r    <= o_pf_nxt;
    o_pfreq_r <= o_pfreq_nxt;
    o_gm_r    <= o_gm_nxt;
  end

  assign out_valid             = ov_r;
  assign out_gain_cross_found  = o_gf_r;
  assign out_gain_cross_freq   = o_gfreq_r;
  assign out_phase_margin      = o_pm_r;
  assign out_phase_cross_found = o_pf_r;
  assign out_phase_cross_freq  = o_pfreq_r;
  assign out_gain_margin       = o_gm_r;

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < den_r))
    else $error("division remainder not below divisor");

  a_t_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (t_r <= T_ONE))
    else $error("interpolation fraction above one");

endmodule

// ----- tb/bode_margin_crossing_finder_unit_tb.sv -----
`timescale 1ns / 1ps
// Testbench for the Bode margin crossing finder: directed sweeps, then random sweeps.
module bode_margin_crossing_finder_unit_tb import bmcf_pkg::*; ();

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic                      gain_found;
    logic [FREQ_W-1:0]         gain_freq;
    logic signed [GAIN_W-1:0]  ph_margin;
    logic                      phase_found;
    logic [FREQ_W-1:0]         phase_freq;
    logic signed [GAIN_W-1:0]  g_margin;
  } margins_t;

  typedef struct {
    logic [FREQ_W-1:0]         f;
    logic signed [GAIN_W-1:0]  g;
    logic signed [PHASE_W-1:0] p;
    logic                      last;
    bit                        typed;
    margins_t                  want;
  } bode_point_t;

  localparam int ITEMS     = 1850;
  localparam int HOLD_OFF  = 300;
  localparam int PH_SPAN   = 360 * ONE_Q16;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [FREQ_W-1:0] in_freq_hz;
  logic signed [GAIN_W-1:0] in_gain_db;
  logic signed [PHASE_W-1:0] in_phase_deg;
  logic in_last_point;
  logic out_valid;
  logic out_ready;
  logic out_gain_cross_found;
  logic [FREQ_W-1:0] out_gain_cross_freq;
  logic signed [GAIN_W-1:0] out_phase_margin;
  logic out_phase_cross_found;
  logic [FREQ_W-1:0] out_phase_cross_freq;
  logic signed [GAIN_W-1:0] out_gain_margin;

  bode_margin_crossing_finder_unit dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_freq_hz            (in_freq_hz),
    .in_gain_db            (in_gain_db),
    .in_phase_deg          (in_phase_deg),
    .in_last_point         (in_last_point),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_gain_cross_found  (out_gain_cross_found),
    .out_gain_cross_freq   (out_gain_cross_freq),
    .out_phase_margin      (out_phase_margin),
    .out_phase_cross_found (out_phase_cross_found),
    .out_phase_cross_freq  (out_phase_cross_freq),
    .out_gain_margin       (out_gain_margin)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sweep state of the margin predictor
  longint sw_freq, sw_gain, sw_phase;
  bit     sw_have, gx_done, px_done;
  logic [FREQ_W-1:0] gx_freq, px_freq;
  logic signed [GAIN_W-1:0] gx_pm, px_gm;

  margins_t    margins_q[$];
  bode_point_t dir_rows[$];
  int  fail_cnt = 0;
  int  shown = 0;
  int  sent = 0;
  bit  hold_req = 1'b0;
  bit  tx_burst = 1'b0;
  bit  rx_burst = 1'b0;

  function automatic u64_t mag(input longint x);
    return (x < 0) ? u64_t'(-x) : u64_t'(x);
  endfunction

  function automatic u64_t cross_frac(input u64_t num, input u64_t den);
    if (den == 0) return 0;
    if (num >= den) return u64_t'(T_ONE);
    return (num << FRAC_BITS) / den;
  endfunction

  function automatic longint span_lerp(input longint a, input longint b, input u64_t t);
    longint d;
    u64_t   p;
    d = b - a;
    p = (mag(d) * t) >> FRAC_BITS;
    return (d < 0) ? a - longint'(p) : a + longint'(p);
  endfunction

  function automatic void clear_sweep();
    sw_freq = 0;
    sw_gain = 0;
    sw_phase = 0;
    sw_have = 1'b0;
    gx_done = 1'b0;
    px_done = 1'b0;
    gx_freq = '0;
    gx_pm = '0;
    px_freq = '0;
    px_gm = '0;
  endfunction

  function automatic void track_point(input bode_point_t r, output bit emit,
                                      output margins_t res);
    longint f1, g1, p1, num, den, gm;
    u64_t   t;
    f1 = longint'({24'd0, r.f});
    g1 = longint'(r.g);
    p1 = longint'(r.p);
    emit = 1'b0;
    res = '0;
    if (sw_have) begin
      if (!gx_done && ((sw_gain >= 0) != (g1 >= 0))) begin
        t = cross_frac(mag(sw_gain), mag(sw_gain - g1));
        gx_freq = FREQ_W'(span_lerp(sw_freq, f1, t));
        gx_pm = GAIN_W'(longint'(PM_BASE) + span_lerp(sw_phase, p1, t));
        gx_done = 1'b1;
      end
      if (!px_done &&
          ((sw_phase > longint'(PH_M181) && p1 <= longint'(PH_M180)) ||
           (sw_phase < longint'(PH_M179) && p1 >= longint'(PH_M180)))) begin
        num = longint'(PH_M180) - sw_phase;
        den = p1 - sw_phase;
        if (den == 0 || num == 0 || ((num < 0) != (den < 0)))
          t = 0;
        else
          t = cross_frac(mag(num), mag(den));
        px_freq = FREQ_W'(span_lerp(sw_freq, f1, t));
        gm = -span_lerp(sw_gain, g1, t);
        if (gm > longint'(GAIN_MAX))
          gm = longint'(GAIN_MAX);
        px_gm = GAIN_W'(gm);
        px_done = 1'b1;
      end
    end
    sw_freq = f1;
    sw_gain = g1;
    sw_phase = p1;
    sw_have = 1'b1;
    if (r.last) begin
      emit = 1'b1;
      res.gain_found = gx_done;
      res.gain_freq = gx_done ? gx_freq : '0;
      res.ph_margin = gx_done ? gx_pm : '0;
      res.phase_found = px_done;
      res.phase_freq = px_done ? px_freq : '0;
      res.g_margin = px_done ? px_gm : '0;
      clear_sweep();
    end
  endfunction

  function automatic bode_point_t mk_point(input longint f, input int g, input int p,
                                           input bit last);
    bode_point_t r;
    r.f = FREQ_W'(f);
    r.g = GAIN_W'(g);
    r.p = PHASE_W'(p);
    r.last = last;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic bode_point_t noise_point(input bit last);
    return mk_point((longint'($urandom_range(0, 255)) << 32) | longint'($urandom()),
                    int'($urandom()), int'($urandom_range(0, 2 * PH_SPAN)) - PH_SPAN, last);
  endfunction

  function automatic void add_row(input longint f, input int g, input int p, input bit last,
                                  input bit typed = 1'b0, input margins_t want = '0);
    bode_point_t r;
    r = mk_point(f, g, p, last);
    r.typed = typed;
    r.want = want;
    dir_rows = {dir_rows, r};
  endfunction

  task automatic offer_point(input bode_point_t r, input int gap);
    bit       emit;
    margins_t m;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_freq_hz    <= r.f;
    in_gain_db    <= r.g;
    in_phase_deg  <= r.p;
    in_last_point <= r.last;
    do @(posedge clk); while (!in_ready);
    track_point(r, emit, m);
    if (emit) begin
      if (r.typed)
        margins_q = {margins_q, r.want};
      else
        margins_q = {margins_q, m};
    end
    sent++;
    @(negedge clk);
  endtask

  function automatic int tx_gap();
    return tx_burst ? 0 : int'($urandom_range(0, 19));
  endfunction

  // result side
  initial begin
    int       stall;
    margins_t got, want;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_OFF;
      end else begin
        stall = rx_burst ? 0 : int'($urandom_range(0, 19));
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = '{out_gain_cross_found, out_gain_cross_freq, out_phase_margin,
              out_phase_cross_found, out_phase_cross_freq, out_gain_margin};
      if (margins_q.size() == 0) begin
        fail_cnt++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result beat at %0t: gf=%0d gfreq=%h pm=%0d pf=%0d pfreq=%h gm=%0d",
                   $realtime, got.gain_found, got.gain_freq, got.ph_margin,
                   got.phase_found, got.phase_freq, got.g_margin);
        end
      end else begin
        want = margins_q.pop_front();
        if (got.gain_found !== want.gain_found || got.gain_freq !== want.gain_freq ||
            got.ph_margin !== want.ph_margin || got.phase_found !== want.phase_found ||
            got.phase_freq !== want.phase_freq || got.g_margin !== want.g_margin) begin
          fail_cnt++;
          if (shown < 10) begin
            shown++;
            $display("mismatch at %0t", $realtime);
            $display("  exp: gf=%0d gfreq=%h pm=%0d pf=%0d pfreq=%h gm=%0d",
                     want.gain_found, want.gain_freq, want.ph_margin,
                     want.phase_found, want.phase_freq, want.g_margin);
            $display("  got: gf=%0d gfreq=%h pm=%0d pf=%0d pfreq=%h gm=%0d",
                     got.gain_found, got.gain_freq, got.ph_margin,
                     got.phase_found, got.phase_freq, got.g_margin);
          end
        end
      end
      if ($urandom_range(0, 15) == 0)
        rx_burst = !rx_burst;
      @(negedge clk);
    end
  end

  initial begin
    #10_000_000;
    $display("** bode_margin_crossing_finder_unit: FAILED **");
    $finish;
  end

  // point side
  initial begin
    bode_point_t sweep[$];
    longint fr;
    int     gn, gd, ph, pd, n, gv, pv;
    bit     paused;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_freq_hz = '0;
    in_gain_db = '0;
    in_phase_deg = '0;
    in_last_point = 1'b0;
    paused = 1'b0;
    clear_sweep();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // single-point sweeps report nothing
    add_row(0, 0, 0, 1'b1, 1'b1, '0);
    add_row(64'hFF_FFFF_FFFF, 32'sh8000_0000, -PH_SPAN, 1'b1, 1'b1, '0);
    add_row(64'hAA_AAAA_AAAA, 32'sh7FFF_FFFF, PH_SPAN, 1'b1, 1'b1, '0);
    // 0 dB crossing half way
    add_row(100 * 256, ONE_Q16, -90 * ONE_Q16, 1'b0);
    add_row(200 * 256, -ONE_Q16, -90 * ONE_Q16, 1'b1, 1'b1,
            '{1'b1, 40'd38400, 32'(90 * ONE_Q16), 1'b0, 40'd0, 32'd0});
    // -180 crossing half way
    add_row(1000 * 256, -10 * ONE_Q16, -170 * ONE_Q16, 1'b0);
    add_row(2000 * 256, -30 * ONE_Q16, -190 * ONE_Q16, 1'b1, 1'b1,
            '{1'b0, 40'd0, 32'd0, 1'b1, 40'd384000, 32'(20 * ONE_Q16)});
    // equal phases at -180 with the most negative gain
    add_row(5000, 32'sh8000_0000, -180 * ONE_Q16, 1'b0);
    add_row(9000, 32'sh8000_0000, -180 * ONE_Q16, 1'b1, 1'b1,
            '{1'b0, 40'd0, 32'd0, 1'b1, 40'd5000, GAIN_MAX});
    add_row(1000, 0, -100 * ONE_Q16, 1'b0);
    add_row(3000, -1, -120 * ONE_Q16, 1'b1);
    // falling frequency
    add_row(90000, 5 * ONE_Q16, -150 * ONE_Q16, 1'b0);
    add_row(10000, -3 * ONE_Q16, -200 * ONE_Q16, 1'b1);
    // only the first crossing counts
    add_row(1000, 2 * ONE_Q16, -170 * ONE_Q16, 1'b0);
    add_row(2000, -2 * ONE_Q16, -190 * ONE_Q16, 1'b0);
    add_row(3000, 2 * ONE_Q16, -170 * ONE_Q16, 1'b0);
    add_row(4000, -2 * ONE_Q16, -190 * ONE_Q16, 1'b1);
    add_row(0, 32'sh7FFF_FFFF, PH_SPAN, 1'b0);
    add_row(64'hFF_FFFF_FFFF, 32'sh8000_0000, -PH_SPAN, 1'b1);
    // fraction clamped to 0, then to 1
    add_row(100, -ONE_Q16, -180 * ONE_Q16 - 32768, 1'b0);
    add_row(200, -2 * ONE_Q16, -200 * ONE_Q16, 1'b1);
    add_row(100, -ONE_Q16, -180 * ONE_Q16 - 32768, 1'b0);
    add_row(200, -2 * ONE_Q16, -180 * ONE_Q16 - 13107, 1'b1);
    add_row(100, -5 * ONE_Q16, -200 * ONE_Q16, 1'b0);
    add_row(300, -6 * ONE_Q16, -170 * ONE_Q16, 1'b1);

    foreach (dir_rows[i])
      offer_point(dir_rows[i], tx_gap());

    // drain, then hold the result side off while single-point sweeps pile up
    in_valid <= 1'b0;
    while (margins_q.size() != 0) @(posedge clk);
    @(negedge clk);
    hold_req = 1'b1;
    tx_burst = 1'b1;
    repeat (16) offer_point(noise_point(1'b1), 0);

    while (sent < ITEMS) begin
      if (!paused && sent >= ITEMS / 2) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        while (margins_q.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      sweep.delete();
      if ($urandom_range(0, 9) < 2) begin
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
          sweep = {sweep, noise_point(k == n - 1)};
      end else begin
        n = ($urandom_range(0, 15) == 0) ? 1 : int'($urandom_range(2, 10));
        fr = longint'($urandom_range(0, 32'h00FF_FFFF));
        if ($urandom_range(0, 7) == 0)
          fr = (longint'($urandom_range(0, 255)) << 32) | longint'($urandom());
        gn = int'($urandom_range(0, 40 * ONE_Q16));
        gd = -int'($urandom_range(1 << 10, 20 * ONE_Q16));
        if ($urandom_range(0, 4) == 0) begin
          gn = -gn;
          gd = -gd;
        end
        ph = -int'($urandom_range(0, 170 * ONE_Q16));
        pd = -int'($urandom_range(0, 50 * ONE_Q16));
        if ($urandom_range(0, 5) == 0) pd = 0;
        if ($urandom_range(0, 5) == 0) pd = -pd;
        for (int k = 0; k < n; k++) begin
          if (ph < -PH_SPAN) ph = -PH_SPAN;
          if (ph > PH_SPAN) ph = PH_SPAN;
          gv = ($urandom_range(0, 11) == 0) ? 0 : gn;
          pv = ($urandom_range(0, 11) == 0) ? -180 * ONE_Q16 : ph;
          if ($urandom_range(0, 9) == 0)
            sweep = {sweep, noise_point(k == n - 1)};
          else
            sweep = {sweep, mk_point(fr, gv, pv, k == n - 1)};
          fr += longint'($urandom_range(1, 1 << 20));
          gn += gd;
          ph += pd + int'($urandom_range(0, 2 * ONE_Q16)) - ONE_Q16;
        end
      end
      tx_burst = ($urandom_range(0, 3) == 0);
      foreach (sweep[i])
        offer_point(sweep[i], tx_gap());
    end
    in_valid <= 1'b0;

    while (margins_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_cnt == 0 && margins_q.size() == 0)
      $display("** bode_margin_crossing_finder_unit: PASSED **");
    else
      $display("** bode_margin_crossing_finder_unit: FAILED **");
    $finish;
  end

endmodule
